// ===== rtl/dll_pkg.sv =====
package dll_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int PTR_W    = IDX_W + 1;
    localparam int CMD_W    = 4;
    localparam int STAT_W   = 2;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

    localparam logic [CMD_W-1:0] CMD_FIRST      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_NEXT       = 4'd1;
    localparam logic [CMD_W-1:0] CMD_LAST       = 4'd2;
    localparam logic [CMD_W-1:0] CMD_PREV       = 4'd3;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd4;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_PUSH_AFTER = 4'd6;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_POP_CURSOR = 4'd9;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd10;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_NODE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic accept;
        logic exec;
        logic fin;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_fin;
    } ctrl_stat_t;

    function automatic logic ptr_ok(input logic [PTR_W-1:0] p);
        return p < NIL;
    endfunction

endpackage

// ===== rtl/doubly_linked_list_with_cursor.sv =====
// A request is registered on acceptance and executed in state EXEC. Moves to first or
// last, pops, clear, failed requests and push back onto an empty list then raise done;
// next, prev (to read the node) and every other successful push (each link memory has
// one write port) take FIN after it. New requests are taken only while busy is low.
// Reset (rst_n, async, active low) empties the list; node memories hold no reset value.
// Results show for one cycle with done high; the receiver cannot stall.
module doubly_linked_list_with_cursor
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [dll_pkg::CMD_W-1:0]   command,
    input  logic [dll_pkg::DATA_W-1:0]  data_in,
    output logic                        done,
    output logic [dll_pkg::DATA_W-1:0]  data_out,
    output logic                        has_data,
    output logic [dll_pkg::STAT_W-1:0]  status
);

    dll_pkg::ctrl_cmd_t  ctl_cmd;
    dll_pkg::ctrl_stat_t ctl_stat;

    dll_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (ctl_stat),
        .cmd   (ctl_cmd),
        .busy  (busy),
        .done  (done)
    );

    dll_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (ctl_cmd),
        .stat     (ctl_stat),
        .command  (command),
        .data_in  (data_in),
        .data_out (data_out),
        .has_data (has_data),
        .status   (status)
    );

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but busy not raised");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe lasted more than one cycle");

    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && has_data |-> status == dll_pkg::ST_OK)
        else $error("data returned with failing status");

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        done && !has_data |-> data_out == '0)
        else $error("nonzero data without has_data");
`endif

endmodule

// ===== rtl/dll_ctrl.sv =====
module dll_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  dll_pkg::ctrl_stat_t stat,
    output dll_pkg::ctrl_cmd_t  cmd,
    output logic                busy,
    output logic                done
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.need_fin)
                    state_next = S_FIN;
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign cmd.accept = (state_reg == S_IDLE) && start;
    assign cmd.exec   = (state_reg == S_EXEC);
    assign cmd.fin    = (state_reg == S_FIN);

endmodule

// ===== rtl/dll_datapath.sv =====
module dll_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  dll_pkg::ctrl_cmd_t                  cmd,
    output dll_pkg::ctrl_stat_t                 stat,
    input  logic [dll_pkg::CMD_W-1:0]           command,
    input  logic [dll_pkg::DATA_W-1:0]          data_in,
    output logic [dll_pkg::DATA_W-1:0]          data_out,
    output logic                                has_data,
    output logic [dll_pkg::STAT_W-1:0]          status
);

    logic [dll_pkg::DATA_W-1:0] data_mem [dll_pkg::CAPACITY];
    logic [dll_pkg::PTR_W-1:0]  next_mem [dll_pkg::CAPACITY];
    logic [dll_pkg::PTR_W-1:0]  prev_mem [dll_pkg::CAPACITY];

    logic [dll_pkg::CMD_W-1:0]    cmd_reg;
    logic [dll_pkg::DATA_W-1:0]   din_reg;
    logic [dll_pkg::PTR_W-1:0]    addr_reg;
    logic [dll_pkg::IDX_W-1:0]    new_reg;
    logic [dll_pkg::CAPACITY-1:0] used_reg, used_next;
    logic [dll_pkg::PTR_W-1:0]    head_reg, head_next;
    logic [dll_pkg::PTR_W-1:0]    tail_reg, tail_next;
    logic [dll_pkg::PTR_W-1:0]    cursor_reg, cursor_next;
    logic [dll_pkg::DATA_W-1:0]   rd_data_reg;
    logic [dll_pkg::PTR_W-1:0]    rd_next_reg;
    logic [dll_pkg::PTR_W-1:0]    rd_prev_reg;
    logic [dll_pkg::DATA_W-1:0]   dout_reg, dout_next;
    logic                         has_reg, has_next;
    logic [dll_pkg::STAT_W-1:0]   stat_reg, stat_next;
    logic                         load_out;

    logic [dll_pkg::PTR_W-1:0]  acc_addr;
    logic [dll_pkg::PTR_W-1:0]  move_tgt;
    logic [dll_pkg::IDX_W-1:0]  free_idx;
    logic                       free_ok;
    logic                       addr_ok;
    logic                       need_fin;

    logic                       data_we;
    logic [dll_pkg::IDX_W-1:0]  data_wa;
    logic                       next_we;
    logic [dll_pkg::IDX_W-1:0]  next_wa;
    logic [dll_pkg::PTR_W-1:0]  next_wd;
    logic                       prev_we;
    logic [dll_pkg::IDX_W-1:0]  prev_wa;
    logic [dll_pkg::PTR_W-1:0]  prev_wd;
    logic [dll_pkg::IDX_W-1:0]  data_ra;

    always_comb
    begin
        case (command)
            dll_pkg::CMD_FIRST, dll_pkg::CMD_PUSH_FRONT, dll_pkg::CMD_POP_FRONT:
                acc_addr = head_reg;
            dll_pkg::CMD_LAST, dll_pkg::CMD_PUSH_BACK, dll_pkg::CMD_POP_BACK:
                acc_addr = tail_reg;
            default:
                acc_addr = cursor_reg;
        endcase
    end

    always_comb
    begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = dll_pkg::CAPACITY - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = dll_pkg::IDX_W'(i);
                free_ok  = 1'b1;
            end
        end
    end

    assign addr_ok  = dll_pkg::ptr_ok(addr_reg);
    assign move_tgt = !addr_ok ? dll_pkg::NIL :
                      (cmd_reg == dll_pkg::CMD_NEXT) ? rd_next_reg : rd_prev_reg;
    assign data_ra  = cmd.accept ? acc_addr[dll_pkg::IDX_W-1:0]
                                 : move_tgt[dll_pkg::IDX_W-1:0];

    always_comb
    begin
        used_next   = used_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cursor_next = cursor_reg;
        dout_next   = '0;
        has_next    = 1'b0;
        stat_next   = dll_pkg::ST_OK;
        need_fin    = 1'b0;
        data_we     = 1'b0;
        data_wa     = free_idx;
        next_we     = 1'b0;
        next_wa     = free_idx;
        next_wd     = dll_pkg::NIL;
        prev_we     = 1'b0;
        prev_wa     = free_idx;
        prev_wd     = dll_pkg::NIL;
        if (cmd.exec)
        begin
            case (cmd_reg)
                dll_pkg::CMD_FIRST, dll_pkg::CMD_LAST:
                begin
                    if (addr_ok)
                    begin
                        cursor_next = addr_reg;
                        dout_next   = rd_data_reg;
                        has_next    = 1'b1;
                    end
                    else
                        stat_next = dll_pkg::ST_NO_NODE;
                end
                dll_pkg::CMD_NEXT, dll_pkg::CMD_PREV:
                begin
                    if (dll_pkg::ptr_ok(move_tgt))
                    begin
                        cursor_next = move_tgt;
                        need_fin    = 1'b1;
                    end
                    else
                        stat_next = dll_pkg::ST_NO_NODE;
                end
                dll_pkg::CMD_PUSH_FRONT:
                begin
                    if (free_ok)
                    begin
                        need_fin            = 1'b1;
                        used_next[free_idx] = 1'b1;
                        data_we             = 1'b1;
                        next_we             = 1'b1;
                        next_wd             = head_reg;
                        prev_we             = addr_ok;
                        prev_wa             = addr_reg[dll_pkg::IDX_W-1:0];
                        prev_wd             = {1'b0, free_idx};
                        head_next           = {1'b0, free_idx};
                        if (!dll_pkg::ptr_ok(tail_reg))
                            tail_next = {1'b0, free_idx};
                    end
                    else
                        stat_next = dll_pkg::ST_FULL;
                end
                dll_pkg::CMD_PUSH_BACK, dll_pkg::CMD_PUSH_AFTER:
                begin
                    if (cmd_reg == dll_pkg::CMD_PUSH_BACK)
                        cursor_next = addr_reg;
                    if (cmd_reg == dll_pkg::CMD_PUSH_AFTER && !addr_ok)
                        stat_next = dll_pkg::ST_NO_NODE;
                    else if (!free_ok)
                        stat_next = dll_pkg::ST_FULL;
                    else
                    begin
                        used_next[free_idx] = 1'b1;
                        data_we             = 1'b1;
                        next_we             = 1'b1;
                        prev_we             = 1'b1;
                        if (!addr_ok)
                        begin
                            head_next = {1'b0, free_idx};
                            tail_next = {1'b0, free_idx};
                        end
                        else
                        begin
                            need_fin = 1'b1;
                            next_wd  = rd_next_reg;
                            prev_wd  = addr_reg;
                            if (addr_reg == tail_reg)
                                tail_next = {1'b0, free_idx};
                        end
                    end
                end
                dll_pkg::CMD_POP_FRONT, dll_pkg::CMD_POP_BACK, dll_pkg::CMD_POP_CURSOR:
                begin
                    cursor_next = addr_reg;
                    if (addr_ok)
                    begin
                        next_we  = dll_pkg::ptr_ok(rd_prev_reg);
                        next_wa  = rd_prev_reg[dll_pkg::IDX_W-1:0];
                        next_wd  = rd_next_reg;
                        prev_we  = dll_pkg::ptr_ok(rd_next_reg);
                        prev_wa  = rd_next_reg[dll_pkg::IDX_W-1:0];
                        prev_wd  = rd_prev_reg;
                        if (addr_reg == head_reg)
                            head_next = rd_next_reg;
                        if (addr_reg == tail_reg)
                            tail_next = rd_prev_reg;
                        cursor_next = dll_pkg::ptr_ok(rd_next_reg) ? rd_next_reg : rd_prev_reg;
                        used_next[addr_reg[dll_pkg::IDX_W-1:0]] = 1'b0;
                        dout_next = rd_data_reg;
                        has_next  = 1'b1;
                    end
                    else
                        stat_next = dll_pkg::ST_NO_NODE;
                end
                dll_pkg::CMD_CLEAR:
                begin
                    used_next   = '0;
                    head_next   = dll_pkg::NIL;
                    tail_next   = dll_pkg::NIL;
                    cursor_next = dll_pkg::NIL;
                end
                default:
                    stat_next = dll_pkg::ST_NO_NODE;
            endcase
        end
        else if (cmd.fin)
        begin
            case (cmd_reg)
                dll_pkg::CMD_NEXT, dll_pkg::CMD_PREV:
                begin
                    dout_next = rd_data_reg;
                    has_next  = 1'b1;
                end
                dll_pkg::CMD_PUSH_FRONT:
                begin
                    prev_we = 1'b1;
                    prev_wa = new_reg;
                    prev_wd = dll_pkg::NIL;
                end
                default:
                begin
                    next_we = 1'b1;
                    next_wa = addr_reg[dll_pkg::IDX_W-1:0];
                    next_wd = {1'b0, new_reg};
                    prev_we = dll_pkg::ptr_ok(rd_next_reg);
                    prev_wa = rd_next_reg[dll_pkg::IDX_W-1:0];
                    prev_wd = {1'b0, new_reg};
                end
            endcase
        end
    end

    assign load_out      = (cmd.exec && !need_fin) || cmd.fin;
    assign stat.need_fin = need_fin;

    always_ff @(posedge clk)
    begin
        if (data_we)
            data_mem[data_wa] <= din_reg;
        if (next_we)
            next_mem[next_wa] <= next_wd;
        if (prev_we)
            prev_mem[prev_wa] <= prev_wd;
        if (cmd.accept || cmd.exec)
            rd_data_reg <= data_mem[data_ra];
        if (cmd.accept)
        begin
            rd_next_reg <= next_mem[acc_addr[dll_pkg::IDX_W-1:0]];
            rd_prev_reg <= prev_mem[acc_addr[dll_pkg::IDX_W-1:0]];
            cmd_reg     <= command;
            din_reg     <= data_in;
            addr_reg    <= acc_addr;
        end
        if (cmd.exec)
            new_reg <= free_idx;
        if (load_out)
        begin
            dout_reg <= dout_next;
            has_reg  <= has_next;
            stat_reg <= stat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            head_reg   <= dll_pkg::NIL;
            tail_reg   <= dll_pkg::NIL;
            cursor_reg <= dll_pkg::NIL;
        end
        else
        begin
            used_reg   <= used_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cursor_reg <= cursor_next;
        end
    end

    assign data_out = dout_reg;
    assign has_data = has_reg;
    assign status   = stat_reg;

endmodule
